// ----- rtl/core/lzbx_pkg.sv -----
// Shared constants and types for the LZ77 back-reference expander.
package lzbx_pkg;

    localparam int PLANE_W       = 25;
    localparam int DIST_W        = 16;
    localparam int LEN_W         = 7;
    localparam int BYTE_W        = 8;
    localparam int MAX_WIDTH     = 16384;
    localparam int HISTORY_DEPTH = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int MAX_COPY      = 64;
    localparam int SHORTEST_COPY = 2;
    localparam int REACH_LIMIT   = 3 * MAX_WIDTH;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    // Command kinds handed from the front to the back
    typedef enum logic [1:0] {
        K_LIT,
        K_COPY,
        K_ERR
    } t_kind;

    // One classified token
    typedef struct packed {
        t_kind               kind;
        logic                done;     // last byte of this command completes the plane
        logic [BYTE_W-1:0]   lit;
        logic [DIST_W-1:0]   distance;
        logic [LEN_W-1:0]    len;
        logic [HIST_AW-1:0]  dst;      // ring address of the first byte written
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              last;
        logic              plane_done;
        logic              error;
    } t_out;

endpackage

// ----- rtl/core/lzbx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzbx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lzbx_front.sv -----
// Token front end: plane size register, position tracking and token classification.
module lzbx_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wen,
    input  logic [lzbx_pkg::PLANE_W-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_start,
    input  logic [lzbx_pkg::DIST_W-1:0]  i_dist,
    input  logic [lzbx_pkg::BYTE_W-1:0]  i_lit,
    input  logic [lzbx_pkg::LEN_W-1:0]   i_len,
    input  logic                         i_full,
    output logic                         o_push,
    output lzbx_pkg::t_cmd               o_cmd
);
    import lzbx_pkg::*;

    logic [PLANE_W-1:0] r_plane_size;
    logic [PLANE_W-1:0] r_pos;
    logic               r_failed;
    logic [PLANE_W-1:0] n_pos;
    logic               n_failed;
    logic [PLANE_W-1:0] pos_eff;
    logic               failed_eff;
    logic [PLANE_W:0]   copy_end;
    logic [PLANE_W-1:0] lit_end;
    logic               complete;
    logic               bad_copy;
    logic               accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // Classify the token against the current position
    always_comb begin
        pos_eff    = i_start ? '0 : r_pos;
        failed_eff = i_start ? 1'b0 : r_failed;
        copy_end   = {1'b0, pos_eff} + (PLANE_W + 1)'(i_len);
        lit_end    = pos_eff + PLANE_W'(1);
        complete   = failed_eff || (pos_eff >= r_plane_size);
        bad_copy   = (32'(i_len) < SHORTEST_COPY) || (32'(i_len) > MAX_COPY) ||
                     (32'(i_dist) > REACH_LIMIT) || (32'(i_dist) > HISTORY_DEPTH) ||
                     (PLANE_W'(i_dist) > pos_eff) ||
                     (copy_end > {1'b0, r_plane_size});

        n_pos          = pos_eff;
        n_failed       = failed_eff;
        o_cmd.kind     = K_ERR;
        o_cmd.done     = 1'b0;
        o_cmd.lit      = i_lit;
        o_cmd.distance = i_dist;
        o_cmd.len      = i_len;
        o_cmd.dst      = pos_eff[HIST_AW-1:0];

        if (complete) begin
            o_cmd.kind = K_ERR;
        end else if (i_dist == '0) begin
            o_cmd.kind = K_LIT;
            o_cmd.done = (lit_end == r_plane_size);
            n_pos      = lit_end;
        end else if (bad_copy) begin
            o_cmd.kind = K_ERR;
            n_failed   = 1'b1;
        end else begin
            o_cmd.kind = K_COPY;
            o_cmd.done = (copy_end == {1'b0, r_plane_size});
            n_pos      = copy_end[PLANE_W-1:0];
        end
    end

    // Hold configuration and plane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_size <= PLANE_W'(1);
            r_pos        <= '0;
            r_failed     <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_plane_size <= i_cfg_wdata;
            end
            if (accept) begin
                r_pos    <= n_pos;
                r_failed <= n_failed;
            end
        end
    end

endmodule

// ----- rtl/core/lzbx_fifo.sv -----
// Short command queue between the front end and the copy engine.
module lzbx_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lzbx_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lzbx_pkg::t_cmd o_head
);
    import lzbx_pkg::*;

    t_cmd               r_slot [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("command queue occupancy beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full command queue");

endmodule

// ----- rtl/core/lzbx_back.sv -----
// Copy engine: executes commands against the history RAM and drives the result register.
module lzbx_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  lzbx_pkg::t_cmd               i_head,
    output logic                         o_pop,
    output logic                         o_we,
    output logic [lzbx_pkg::HIST_AW-1:0] o_waddr,
    output logic [lzbx_pkg::BYTE_W-1:0]  o_wdata,
    output logic                         o_re,
    output logic [lzbx_pkg::HIST_AW-1:0] o_raddr,
    input  logic [lzbx_pkg::BYTE_W-1:0]  i_rdata,
    output logic                         o_valid,
    input  logic                         i_ready,
    output lzbx_pkg::t_out               o_out
);
    import lzbx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [HIST_AW-1:0] r_src;
    logic [HIST_AW-1:0] n_src;
    logic [HIST_AW-1:0] r_dst;
    logic [HIST_AW-1:0] n_dst;
    logic [LEN_W-1:0]   r_cnt;
    logic [LEN_W-1:0]   n_cnt;
    logic               r_done;
    logic               n_done;
    logic               r_out_valid;
    t_out               r_out;
    t_out               n_out;
    logic               emit;
    logic               out_free;
    logic               copy_last;

    assign out_free  = !r_out_valid || i_ready;
    assign copy_last = (r_cnt == LEN_W'(1));
    assign o_raddr   = r_src;
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;

    // Sequence commands: literal and error from idle, copy as read then write per byte
    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        n_dst   = r_dst;
        n_cnt   = r_cnt;
        n_done  = r_done;
        n_out   = r_out;
        emit    = 1'b0;
        o_pop   = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_dst;
        o_wdata = i_rdata;
        o_re    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_head.kind)
                        K_LIT: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                o_we    = 1'b1;
                                o_waddr = i_head.dst;
                                o_wdata = i_head.lit;
                                emit    = 1'b1;
                                n_out   = '{byte_value: i_head.lit, last: 1'b1,
                                            plane_done: i_head.done, error: 1'b0};
                            end
                        end
                        K_COPY: begin
                            o_pop   = 1'b1;
                            n_src   = i_head.dst - i_head.distance[HIST_AW-1:0];
                            n_dst   = i_head.dst;
                            n_cnt   = i_head.len;
                            n_done  = i_head.done;
                            n_state = ST_RD;
                        end
                        K_ERR: begin
                            if (out_free) begin
                                o_pop = 1'b1;
                                emit  = 1'b1;
                                n_out = '{byte_value: '0, last: 1'b1,
                                          plane_done: 1'b0, error: 1'b1};
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD: begin
                o_re    = 1'b1;
                n_state = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    o_we    = 1'b1;
                    emit    = 1'b1;
                    n_out   = '{byte_value: i_rdata, last: copy_last,
                                plane_done: r_done && copy_last, error: 1'b0};
                    n_src   = r_src + HIST_AW'(1);
                    n_dst   = r_dst + HIST_AW'(1);
                    n_cnt   = r_cnt - LEN_W'(1);
                    n_state = copy_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, copy pointers and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_cnt  <= n_cnt;
        r_done <= n_done;
        r_out  <= n_out;
    end

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |->
            (r_out.byte_value == '0) && r_out.last && !r_out.plane_done)
        else $error("malformed error result");

    a_wr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> (r_cnt != '0))
        else $error("copy write with no bytes left");

    a_rd_to_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |=> (r_state == ST_WR))
        else $error("history read not followed by write step");

endmodule

// ----- rtl/core/lz77_backref_expander.sv -----
// LZ77 back-reference expander: decoded tokens in, plane bytes out, one result per byte.
// Each token is checked as it is accepted; a short command queue lets token intake
// run ahead of byte output. A literal or a rejected token is handled directly from idle in
// the copy engine; a back reference is copied one byte at a time, since every copied byte
// needs a registered read of the 64 KiB history RAM followed by its write (so a copy
// may overlap the bytes it is producing). The output register is freed whenever the
// sink takes a transaction. plane_size must be written only while the block is idle.
module lz77_backref_expander (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wen,
    input  logic [lzbx_pkg::PLANE_W-1:0] i_cfg_wdata,     // plane_size
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [31:0]                  i_s_axis_tdata,  // distance[15:0], literal[23:16],
                                                          // copy_length[30:24], zero[31]
    input  logic                         i_s_axis_tuser,  // start_of_plane
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [7:0]                   o_m_axis_tdata,  // byte_value
    output logic                         o_m_axis_tlast,  // last
    output logic [1:0]                   o_m_axis_tuser   // plane_done[0], error[1]
);
    import lzbx_pkg::*;

    logic               push;
    t_cmd               cmd;
    logic               full;
    logic               pop;
    logic               empty;
    t_cmd               head;
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
    logic [BYTE_W-1:0]  rdata;
    t_out               out;

    lzbx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_start     (i_s_axis_tuser),
        .i_dist      (i_s_axis_tdata[15:0]),
        .i_lit       (i_s_axis_tdata[23:16]),
        .i_len       (i_s_axis_tdata[30:24]),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    lzbx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    lzbx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_out   (out)
    );

    lzbx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_m_axis_tdata = out.byte_value;
    assign o_m_axis_tlast = out.last;
    assign o_m_axis_tuser = {out.error, out.plane_done};

endmodule

// ----- tb/lz77_backref_expander_tb.sv -----
// Testbench for the LZ77 back-reference expander: token stream in, plane bytes checked out.
`timescale 1ns / 100ps

module lz77_backref_expander_tb;

    import lzbx_pkg::*;

    localparam int RANDOM_TOKENS = 72;
    localparam int QUIET_TOKENS  = 20;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_CAP     = 50;

    // One input token as the block sees it
    typedef struct packed {
        logic                sop;
        logic [DIST_W-1:0]   distance;
        logic [BYTE_W-1:0]   lit;
        logic [LEN_W-1:0]    len;
    } t_token;

    // Plane expansion predictor and store of pending plane bytes
    class expansion_scoreboard;
        logic [BYTE_W-1:0]  ring [HISTORY_DEPTH];
        logic [PLANE_W-1:0] pos;
        logic [PLANE_W-1:0] plane_size;
        bit                 failed;
        t_out               pending_bytes [$];
        int                 mismatches;
        int                 n_tokens;
        int                 n_bytes;
        int                 n_rejects;
        int                 n_planes;

        function new();
            pos        = '0;
            plane_size = PLANE_W'(1);
            failed     = 1'b0;
            mismatches = 0;
            n_tokens   = 0;
            n_bytes    = 0;
            n_rejects  = 0;
            n_planes   = 0;
        endfunction

        function void set_plane_size(logic [PLANE_W-1:0] value);
            plane_size = value;
        endfunction

        function void push_reject();
            t_out r;
            r.byte_value = '0;
            r.last       = 1'b1;
            r.plane_done = 1'b0;
            r.error      = 1'b1;
            pending_bytes.push_back(r);
        endfunction

        // Expand one accepted token into the plane bytes it must produce
        function void note_token(t_token tk);
            t_out        r;
            int unsigned k;
            logic [PLANE_W-1:0] src;

            n_tokens++;
            if (tk.sop) begin
                pos    = '0;
                failed = 1'b0;
            end
            // Failed plane or plane already complete
            if (failed || pos >= plane_size) begin
                push_reject();
                return;
            end
            // Literal: copy_length is a don't-care
            if (tk.distance == '0) begin
                ring[pos[HIST_AW-1:0]] = tk.lit;
                pos++;
                r.byte_value = tk.lit;
                r.last       = 1'b1;
                r.plane_done = (pos == plane_size);
                r.error      = 1'b0;
                pending_bytes.push_back(r);
                return;
            end
            // Bad length, distance too far or beyond position, or overrun
            if (tk.len < SHORTEST_COPY || tk.len > MAX_COPY || tk.distance > REACH_LIMIT ||
                tk.distance > HISTORY_DEPTH || tk.distance > pos ||
                int'(pos) + int'(tk.len) > int'(plane_size)) begin
                failed = 1'b1;
                push_reject();
                return;
            end
            // Byte-by-byte copy so overlapping references repeat fresh bytes
            for (k = 0; k < tk.len; k++) begin
                src = pos - tk.distance;
                ring[pos[HIST_AW-1:0]] = ring[src[HIST_AW-1:0]];
                r.byte_value = ring[src[HIST_AW-1:0]];
                pos++;
                r.last       = (k + 1 == tk.len);
                r.plane_done = (pos == plane_size);
                r.error      = 1'b0;
                pending_bytes.push_back(r);
            end
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // Compare one accepted plane byte with the oldest pending one
        task check_result(t_out got);
            t_out want;
            if (pending_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected byte %02h tlast %0b tuser %0b%0b",
                              got.byte_value, got.last, got.error, got.plane_done));
                return;
            end
            want = pending_bytes.pop_front();
            n_bytes++;
            if (want.error)
                n_rejects++;
            if (want.plane_done)
                n_planes++;
            if (got.byte_value !== want.byte_value)
                flag_mismatch($sformatf("byte_value got %02h want %02h",
                              got.byte_value, want.byte_value));
            if (got.last !== want.last)
                flag_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
            if (got.plane_done !== want.plane_done)
                flag_mismatch($sformatf("plane_done got %0b want %0b",
                              got.plane_done, want.plane_done));
            if (got.error !== want.error)
                flag_mismatch($sformatf("error got %0b want %0b", got.error, want.error));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_wen        = 1'b0;
    logic [PLANE_W-1:0]   i_cfg_wdata      = '0;
    logic                 i_s_axis_tvalid  = 1'b0;
    logic                 o_s_axis_tready;
    logic [31:0]          i_s_axis_tdata   = '0;
    logic                 i_s_axis_tuser   = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready  = 1'b1;
    logic [7:0]           o_m_axis_tdata;
    logic                 o_m_axis_tlast;
    logic [1:0]           o_m_axis_tuser;

    expansion_scoreboard sb = new();
    bit                  quiet = 1'b0;
    int                  sink_hold = 0;

    lz77_backref_expander u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sink: check every output transaction, stall in short random bursts unless quiet
    always @(posedge i_clk) begin
        t_out got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.byte_value = o_m_axis_tdata;
            got.last       = o_m_axis_tlast;
            got.plane_done = o_m_axis_tuser[0];
            got.error      = o_m_axis_tuser[1];
            sb.check_result(got);
        end
        if (sink_hold > 0 && !quiet) begin
            sink_hold--;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            sink_hold = $urandom_range(1, 4) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Present one token, hold it until the transaction completes, then record it
    task automatic send_token(input t_token tk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, tk.len, tk.lit, tk.distance};
        i_s_axis_tuser  <= tk.sop;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        sb.note_token(tk);
    endtask

    task automatic send(input logic sop, input int distance, input int lit, input int len);
        t_token tk;
        tk.sop      = sop;
        tk.distance = DIST_W'(distance);
        tk.lit      = BYTE_W'(lit);
        tk.len      = LEN_W'(len);
        send_token(tk);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write plane_size once the block has gone idle
    task automatic write_plane_size(input logic [PLANE_W-1:0] value);
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        sb.set_plane_size(value);
    endtask

    // Build a token: mostly legal for the current plane state, else random noise
    function automatic t_token make_token(bit tidy, bit start);
        t_token      tk;
        int unsigned p;
        int unsigned room;
        int unsigned dmax;
        int unsigned lmax;

        tk.sop      = start;
        tk.lit      = BYTE_W'($urandom);
        tk.len      = LEN_W'($urandom);
        tk.distance = '0;
        if (!tidy) begin
            tk.sop = start | ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 3))
                0: begin
                    tk.distance = '0;
                end
                1: begin
                    tk.distance = DIST_W'($urandom_range(1, 16));
                end
                default: begin
                    tk.distance = DIST_W'($urandom);
                end
            endcase
            return tk;
        end
        p = sb.pos;
        if (start || sb.failed || p >= sb.plane_size || $urandom_range(0, 19) == 0) begin
            tk.sop = 1'b1;
            p      = 0;
        end
        room = (sb.plane_size > p) ? sb.plane_size - p : 0;
        if (p == 0 || room < SHORTEST_COPY || $urandom_range(0, 9) < 4)
            return tk;
        dmax = (p < REACH_LIMIT) ? p : REACH_LIMIT;
        lmax = (room < MAX_COPY) ? room : MAX_COPY;
        if ($urandom_range(0, 1) == 0)
            tk.distance = DIST_W'($urandom_range(1, (dmax < 8) ? dmax : 8));
        else
            tk.distance = DIST_W'($urandom_range(1, dmax));
        tk.len = LEN_W'($urandom_range(SHORTEST_COPY, lmax));
        return tk;
    endfunction

    initial begin
        int                 n_random;
        int                 n_phase;
        int                 i;
        logic [PLANE_W-1:0] size;
        t_token             tk;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2^24-byte plane: literal extremes, overlapping copies, distance equal to position
        write_plane_size(PLANE_W'(16777216));
        send(1'b1, 0, 8'h00, 127);
        send(1'b0, 0, 8'hFF, 0);
        send(1'b0, 1, 8'h33, 2);
        send(1'b0, 3, 8'hCC, MAX_COPY);
        send(1'b0, 68, 8'h00, 5);
        // Distance beyond position fails the plane, then everything is rejected
        send(1'b0, 80, 8'h00, 4);
        send(1'b0, 0, 8'h12, 3);
        // Length below and above the legal range
        send(1'b1, 0, 8'hA5, 1);
        send(1'b0, 1, 8'h00, 1);
        send(1'b1, 0, 8'h5A, 0);
        send(1'b0, 1, 8'h00, MAX_COPY + 1);
        // Distance past the largest legal value, and all-ones fields
        send(1'b1, 0, 8'h81, 64);
        send(1'b0, REACH_LIMIT + 1, 8'h00, 2);
        send(1'b1, 0, 8'h7E, 9);
        send(1'b0, 16'hFFFF, 8'hFF, 7'h7F);

        // Tiny plane: overrun, exact completion, then tokens after completion
        write_plane_size(PLANE_W'(4));
        send(1'b1, 0, 8'h01, 0);
        send(1'b0, 1, 8'h00, 4);
        send(1'b1, 0, 8'h02, 0);
        send(1'b0, 1, 8'h00, 3);
        send(1'b0, 0, 8'h44, 0);
        send(1'b0, 1, 8'h00, 2);

        // Smallest plane, then zero plane size
        write_plane_size(PLANE_W'(1));
        send(1'b1, 0, 8'h5A, 0);
        send(1'b0, 0, 8'h66, 0);
        write_plane_size('0);
        send(1'b1, 0, 8'h77, 0);
        send(1'b1, 1, 8'h00, 2);

        // Random phases, each with its own plane size
        n_random = 0;
        while (n_random < RANDOM_TOKENS) begin
            case ($urandom_range(0, 9))
                0: begin
                    size = PLANE_W'(1);
                end
                1: begin
                    size = PLANE_W'(16777216);
                end
                2: begin
                    size = PLANE_W'($urandom_range(1, 16777216));
                end
                3, 4, 5: begin
                    size = PLANE_W'($urandom_range(2, 12));
                end
                default: begin
                    size = PLANE_W'($urandom_range(13, 200));
                end
            endcase
            write_plane_size(size);
            n_phase = $urandom_range(6, 20);
            i = 0;
            while (i < n_phase && n_random < RANDOM_TOKENS) begin
                quiet = (n_random >= RANDOM_TOKENS - QUIET_TOKENS);
                tk = make_token($urandom_range(0, 99) < 85,
                                i == 0 && $urandom_range(0, 3) != 0);
                send_token(tk);
                n_random++;
                i++;
            end
        end

        // Let every pending byte arrive, then watch for strays
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d tokens, %0d output bytes checked, %0d rejected tokens,",
                 sb.n_tokens, sb.n_bytes, sb.n_rejects);
        $display("%0d completed planes, sizes from zero to the largest", sb.n_planes);
        if (sb.mismatches == 0)
            $display("lz77_backref_expander_tb: done, clean");
        else
            $display("lz77_backref_expander_tb: done, errors");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #2000000;
        $display("timeout waiting on the block");
        $display("lz77_backref_expander_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lzbx_pkg.sv
rtl/core/lzbx_ram.sv
rtl/core/lzbx_front.sv
rtl/core/lzbx_fifo.sv
rtl/core/lzbx_back.sv
rtl/core/lz77_backref_expander.sv
tb/lz77_backref_expander_tb.sv
